// ===== src/bllq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the bounded linked list queue core.
package bllq_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned HDL_W = 6;
  localparam int unsigned POS_W = 6;

  typedef enum logic [2:0] {
    KIND_APPEND    = 3'd0,
    KIND_FRONT     = 3'd1,
    KIND_INS_AFTER = 3'd2,
    KIND_TAKE      = 3'd3,
    KIND_REMOVE    = 3'd4,
    KIND_GET       = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_ITEM_ZERO,
    WR_TAIL_ITEM,
    WR_ITEM_HEAD,
    WR_ITEM_RDATA,
    WR_PRIOR_ITEM,
    WR_PRED_ZERO,
    WR_PRED_RDATA
  } wr_sel_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_FRONT,
    ACT_INS_AFTER,
    ACT_TAKE,
    ACT_REMOVE,
    ACT_GET
  } act_t;

  typedef struct packed {
    logic    load;
    logic    walk_start;
    logic    walk_step;
    logic    read_head;
    wr_sel_t wr_sel;
    act_t    act;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  count_one;
    logic  pos_ok;
    logic  walk_end;
    logic  walk_hit;
    logic  at_head;
    logic  item_is_tail;
    logic  out_busy;
  } sts_t;

endpackage

// ===== src/bllq_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bllq_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bllq_dp.sv =====
`timescale 1ns / 1ps
// Datapath: link memory, head/tail/count/peak registers, walk pointers and result register.
module bllq_dp #(
  parameter int unsigned HANDLES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              cfg_wr_en,
  input  logic [6:0]        cfg_wr_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tuser,
  input  bllq_pkg::cmd_t    cmd,
  output bllq_pkg::sts_t    sts
);
  import bllq_pkg::*;

  localparam int unsigned AW = $clog2(HANDLES);

  function automatic logic [AW-1:0] hred(logic [HDL_W-1:0] h);
    int r;
    r = int'(h);
    for (int k = HDL_W - 1; k >= 0; k--) begin
      if (r >= (int'(HANDLES) << k)) begin
        r = r - (int'(HANDLES) << k);
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [HDL_W-1:0] to_hdl(logic [AW-1:0] x);
    logic [31:0] w;
    w = 32'(x);
    return w[HDL_W-1:0];
  endfunction

  kind_t            kind_r;
  logic [AW-1:0]    item_r;
  logic [AW-1:0]    prior_r;
  logic [POS_W-1:0] pos_r;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0] max_r;
  logic [AW-1:0]    cur_r;
  logic [AW-1:0]    prev_r;
  logic [CNT_W-1:0] idx_r;
  logic             ok_r, ok_nxt;
  logic [HDL_W-1:0] res_r, res_nxt;
  logic             out_valid_r;
  logic             out_ok_r;
  logic [HDL_W-1:0] out_res_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] out_peak_r;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    wdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    rdata;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic             walk_hit;

  bllq_ram #(
    .WIDTH (AW),
    .DEPTH (HANDLES)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr = cmd.read_head ? head_r : cur_r;

  always_comb begin
    we    = 1'b1;
    waddr = item_r;
    wdata = '0;
    unique case (cmd.wr_sel)
      WR_NONE:       we = 1'b0;
      WR_ITEM_ZERO:  begin waddr = item_r;  wdata = '0;     end
      WR_TAIL_ITEM:  begin waddr = tail_r;  wdata = item_r; end
      WR_ITEM_HEAD:  begin waddr = item_r;  wdata = head_r; end
      WR_ITEM_RDATA: begin waddr = item_r;  wdata = rdata;  end
      WR_PRIOR_ITEM: begin waddr = prior_r; wdata = item_r; end
      WR_PRED_ZERO:  begin waddr = prev_r;  wdata = '0;     end
      WR_PRED_RDATA: begin waddr = prev_r;  wdata = rdata;  end
      default:       we = 1'b0;
    endcase
  end

  assign count_inc = count_r + CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  always_comb begin
    unique case (kind_r)
      KIND_INS_AFTER: walk_hit = (cur_r == prior_r);
      KIND_REMOVE:    walk_hit = (cur_r == item_r);
      KIND_GET:       walk_hit = (idx_r == {1'b0, pos_r});
      default:        walk_hit = 1'b0;
    endcase
  end

  always_comb begin
    sts.kind         = kind_r;
    sts.full         = (count_r >= max_r);
    sts.empty        = (count_r == '0);
    sts.count_one    = (count_r == CNT_W'(1));
    sts.pos_ok       = ({1'b0, pos_r} < count_r);
    sts.walk_end     = (idx_r == count_r);
    sts.walk_hit     = walk_hit;
    sts.at_head      = (idx_r == '0);
    sts.item_is_tail = (item_r == tail_r);
    sts.out_busy     = out_valid_r && !out_tready;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    peak_nxt  = peak_r;
    ok_nxt    = ok_r;
    res_nxt   = res_r;
    if (cmd.load) begin
      ok_nxt  = 1'b0;
      res_nxt = '0;
    end
    unique case (cmd.act)
      ACT_NONE: ;
      ACT_APPEND, ACT_FRONT, ACT_INS_AFTER: begin
        count_nxt = count_inc;
        if (count_inc > peak_r) begin
          peak_nxt = count_inc;
        end
        ok_nxt = 1'b1;
        if (cmd.act == ACT_APPEND) begin
          tail_nxt = item_r;
          if (count_r == '0) begin
            head_nxt = item_r;
          end
        end else if (cmd.act == ACT_FRONT) begin
          head_nxt = item_r;
          if (count_r == '0) begin
            tail_nxt = item_r;
          end
        end else if (tail_r == prior_r) begin
          tail_nxt = item_r;
        end
      end
      ACT_TAKE: begin
        res_nxt   = to_hdl(head_r);
        count_nxt = count_dec;
        ok_nxt    = 1'b1;
        if (count_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          head_nxt = rdata;
        end
      end
      ACT_REMOVE: begin
        count_nxt = count_dec;
        ok_nxt    = 1'b1;
        if (count_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (idx_r == '0) begin
          head_nxt = rdata;
        end else if (item_r == tail_r) begin
          tail_nxt = prev_r;
        end
      end
      ACT_GET: begin
        res_nxt = to_hdl(cur_r);
        ok_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      peak_r      <= '0;
      max_r       <= CNT_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    res_r <= res_nxt;
    if (cmd.load) begin
      kind_r  <= kind_t'(in_tuser);
      item_r  <= hred(in_tdata[5:0]);
      prior_r <= hred(in_tdata[11:6]);
      pos_r   <= in_tdata[17:12];
    end
    if (cmd.walk_start) begin
      cur_r  <= head_r;
      prev_r <= '0;
      idx_r  <= '0;
    end else if (cmd.walk_step) begin
      cur_r  <= rdata;
      prev_r <= cur_r;
      idx_r  <= idx_r + CNT_W'(1);
    end
    if (cmd.finish) begin
      out_ok_r   <= ok_r;
      out_res_r  <= res_r;
      out_cnt_r  <= count_r;
      out_peak_r <= peak_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {4'b0, out_peak_r, out_cnt_r, out_res_r};

  a_peak_bounds_count: assert property (@(posedge clk) disable iff (!rst_n)
    peak_r >= count_r)
    else $error("peak below live count");

  a_empty_clears_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty list with nonzero head or tail");

endmodule

// ===== src/bllq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences each request through link memory reads, walks and writes.
module bllq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bllq_pkg::sts_t sts,
  output bllq_pkg::cmd_t cmd
);
  import bllq_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DISPATCH  = 11'b000_0000_0010,
    ST_APPEND2   = 11'b000_0000_0100,
    ST_INS_LINK  = 11'b000_0000_1000,
    ST_INS_PRIOR = 11'b000_0001_0000,
    ST_TAKE_RD   = 11'b000_0010_0000,
    ST_TAKE_ACT  = 11'b000_0100_0000,
    ST_WALK_CMP  = 11'b000_1000_0000,
    ST_WALK_NEXT = 11'b001_0000_0000,
    ST_REM_FIX   = 11'b010_0000_0000,
    ST_FINISH    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_FINISH;
        unique case (sts.kind)
          KIND_APPEND: begin
            if (!sts.full) begin
              cmd.wr_sel = WR_ITEM_ZERO;
              if (sts.empty) begin
                cmd.act = ACT_APPEND;
              end else begin
                state_nxt = ST_APPEND2;
              end
            end
          end
          KIND_FRONT: begin
            if (!sts.full) begin
              cmd.wr_sel = WR_ITEM_HEAD;
              cmd.act    = ACT_FRONT;
            end
          end
          KIND_INS_AFTER: begin
            if (!sts.full) begin
              cmd.walk_start = 1'b1;
              state_nxt      = ST_WALK_CMP;
            end
          end
          KIND_TAKE: begin
            if (!sts.empty) begin
              state_nxt = ST_TAKE_RD;
            end
          end
          KIND_REMOVE: begin
            cmd.walk_start = 1'b1;
            state_nxt      = ST_WALK_CMP;
          end
          KIND_GET: begin
            if (sts.pos_ok) begin
              cmd.walk_start = 1'b1;
              state_nxt      = ST_WALK_CMP;
            end
          end
          default: ;
        endcase
      end
      ST_APPEND2: begin
        cmd.wr_sel = WR_TAIL_ITEM;
        cmd.act    = ACT_APPEND;
        state_nxt  = ST_FINISH;
      end
      ST_TAKE_RD: begin
        cmd.read_head = 1'b1;
        state_nxt     = ST_TAKE_ACT;
      end
      ST_TAKE_ACT: begin
        cmd.act   = ACT_TAKE;
        state_nxt = ST_FINISH;
      end
      ST_WALK_CMP: begin
        priority if (sts.walk_end) begin
          state_nxt = ST_FINISH;
        end else if (sts.walk_hit) begin
          if (sts.kind == KIND_INS_AFTER) begin
            state_nxt = ST_INS_LINK;
          end else if (sts.kind == KIND_REMOVE) begin
            state_nxt = ST_REM_FIX;
          end else begin
            cmd.act   = ACT_GET;
            state_nxt = ST_FINISH;
          end
        end else begin
          state_nxt = ST_WALK_NEXT;
        end
      end
      ST_WALK_NEXT: begin
        cmd.walk_step = 1'b1;
        state_nxt     = ST_WALK_CMP;
      end
      ST_INS_LINK: begin
        cmd.wr_sel = WR_ITEM_RDATA;
        state_nxt  = ST_INS_PRIOR;
      end
      ST_INS_PRIOR: begin
        cmd.wr_sel = WR_PRIOR_ITEM;
        cmd.act    = ACT_INS_AFTER;
        state_nxt  = ST_FINISH;
      end
      ST_REM_FIX: begin
        cmd.act = ACT_REMOVE;
        priority if (sts.count_one || sts.at_head) begin
          cmd.wr_sel = WR_NONE;
        end else if (sts.item_is_tail) begin
          cmd.wr_sel = WR_PRED_ZERO;
        end else begin
          cmd.wr_sel = WR_PRED_RDATA;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_finish_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.out_busy)
    else $error("result loaded while previous result still stalled");

  a_walk_stays_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> !sts.walk_end)
    else $error("walk stepped past live count");

  a_step_follows_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_CMP && !sts.walk_end && !sts.walk_hit) |=> cmd.walk_step)
    else $error("walk miss not followed by a link step");

endmodule

// ===== src/bounded_linked_list_queue_core.sv =====
`timescale 1ns / 1ps
// Bounded singly linked list queue manager: one result transaction per request transaction.
// Requests are handled one at a time: accepted in idle, decoded in dispatch, ended in a finish
// state that loads the result register. Append to a non-empty list adds a tail link write and
// take head a head read. Insert after, remove handle and get at position walk the list from
// the head through the link memory, with a compare state and a step state per link walked, up
// to entry_count links; insert after then relinks in its link and prior states, remove in its
// fix state. A finished result waits in an output register; while it is stalled the next
// request is still accepted and processed, and its result is held until the register frees.
module bounded_linked_list_queue_core #(
  parameter int unsigned HANDLES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // item_handle[5:0], prior_handle[11:6], position[17:12]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // result_handle[5:0], entry_count[12:6], peak_count[19:13]
  output logic        out_tuser,  // ok[0]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data // max_entries
);
  import bllq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bllq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bllq_dp #(
    .HANDLES (HANDLES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded linked list queue core, checked against its own list predictor.
module tb_top;
  import bllq_pkg::*;

  localparam logic [2:0] KIND_UNUSED6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED7 = 3'd7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_HANDLES = 64;

  typedef struct packed {
    logic       ok;
    logic [5:0] handle;
    logic [6:0] count;
    logic [6:0] peak;
  } list_reply_t;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  item;
    logic [5:0]  prior;
    logic [5:0]  pos;
    bit          typed;
    list_reply_t reply;
  } req_row_t;

  typedef enum {RX_STREAM, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  bit          req_typed;
  list_reply_t req_typed_reply;

  logic [5:0]  link_mem [NUM_HANDLES];
  logic [5:0]  head_h;
  logic [5:0]  tail_h;
  logic [6:0]  live_cnt;
  logic [6:0]  peak_cnt;
  logic [6:0]  max_entries_m;

  list_reply_t reply_q [$];
  req_row_t    directed_q [$];
  int          err_count;
  int          cycles;
  int          burst_left;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          mode_left;
  rx_mode_t    rx_mode;

  bounded_linked_list_queue_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void grow_list();
    live_cnt = live_cnt + 7'd1;
    if (live_cnt > peak_cnt) begin
      peak_cnt = live_cnt;
    end
  endfunction

  function automatic bit find_link(input logic [5:0] h, output logic [5:0] pred, output int at);
    logic [5:0] cur;
    logic [5:0] prev;
    int i;
    cur = head_h;
    prev = '0;
    pred = '0;
    at = 0;
    for (i = 0; i < live_cnt; i++) begin
      if (cur == h) begin
        pred = prev;
        at = i;
        return 1'b1;
      end
      prev = cur;
      cur = link_mem[cur];
    end
    return 1'b0;
  endfunction

  function automatic list_reply_t apply_request(input logic [2:0] k, input logic [5:0] it,
                                                input logic [5:0] pr, input logic [5:0] ps);
    list_reply_t rep;
    logic [5:0] pred;
    logic [5:0] cur;
    int at;
    int i;
    logic full;
    rep = '0;
    full = (live_cnt >= max_entries_m);
    case (k)
      KIND_APPEND: begin
        if (!full) begin
          link_mem[it] = '0;
          if (live_cnt == 0) head_h = it;
          else link_mem[tail_h] = it;
          tail_h = it;
          grow_list();
          rep.ok = 1'b1;
        end
      end
      KIND_FRONT: begin
        if (!full) begin
          link_mem[it] = head_h;
          head_h = it;
          if (live_cnt == 0) tail_h = it;
          grow_list();
          rep.ok = 1'b1;
        end
      end
      KIND_INS_AFTER: begin
        if (!full && find_link(pr, pred, at)) begin
          link_mem[it] = link_mem[pr];
          link_mem[pr] = it;
          if (tail_h == pr) tail_h = it;
          grow_list();
          rep.ok = 1'b1;
        end
      end
      KIND_TAKE: begin
        if (live_cnt != 0) begin
          rep.handle = head_h;
          if (live_cnt == 1) begin
            head_h = '0;
            tail_h = '0;
          end else begin
            head_h = link_mem[head_h];
          end
          live_cnt = live_cnt - 7'd1;
          rep.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (find_link(it, pred, at)) begin
          live_cnt = live_cnt - 7'd1;
          if (live_cnt == 0) begin
            head_h = '0;
            tail_h = '0;
          end else if (at == 0) begin
            head_h = link_mem[it];
          end else if (it == tail_h) begin
            tail_h = pred;
            link_mem[pred] = '0;
          end else begin
            link_mem[pred] = link_mem[it];
          end
          rep.ok = 1'b1;
        end
      end
      KIND_GET: begin
        if (ps < live_cnt) begin
          cur = head_h;
          for (i = 0; i < ps; i++) cur = link_mem[cur];
          rep.handle = cur;
          rep.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rep.count = live_cnt;
    rep.peak = peak_cnt;
    return rep;
  endfunction

  function automatic logic [5:0] pick_live();
    logic [5:0] cur;
    int n;
    if (live_cnt == 0 || $urandom_range(0, 4) == 0) return 6'($urandom_range(0, 63));
    n = $urandom_range(0, int'(live_cnt) - 1);
    cur = head_h;
    repeat (n) cur = link_mem[cur];
    return cur;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  task automatic issue(input logic [2:0] k, input logic [5:0] it, input logic [5:0] pr,
                       input logic [5:0] ps, input bit typed, input list_reply_t rep);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, ps, pr, it};
    in_tuser <= k;
    req_typed <= typed;
    req_typed_reply <= rep;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  task automatic set_max_entries(input logic [6:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_row(input logic [2:0] k, input logic [5:0] it, input logic [5:0] pr,
                         input logic [5:0] ps, input bit typed, input list_reply_t rep);
    req_row_t r;
    r.kind = k;
    r.item = it;
    r.prior = pr;
    r.pos = ps;
    r.typed = typed;
    r.reply = rep;
    directed_q.push_back(r);
  endtask

  task automatic random_request(input int target);
    int r;
    logic [2:0] k;
    logic [5:0] it;
    logic [5:0] pr;
    logic [5:0] ps;
    r = $urandom_range(0, 99);
    it = 6'($urandom_range(0, 63));
    pr = pick_live();
    ps = 6'($urandom_range(0, 63));
    if (live_cnt < target) begin
      if (r < 30) k = KIND_APPEND;
      else if (r < 50) k = KIND_FRONT;
      else if (r < 70) k = KIND_INS_AFTER;
      else if (r < 80) k = KIND_TAKE;
      else if (r < 90) k = KIND_REMOVE;
      else if (r < 98) k = KIND_GET;
      else k = $urandom_range(0, 1) ? KIND_UNUSED6 : KIND_UNUSED7;
    end else begin
      if (r < 10) k = KIND_APPEND;
      else if (r < 15) k = KIND_FRONT;
      else if (r < 25) k = KIND_INS_AFTER;
      else if (r < 60) k = KIND_TAKE;
      else if (r < 85) k = KIND_REMOVE;
      else if (r < 98) k = KIND_GET;
      else k = $urandom_range(0, 1) ? KIND_UNUSED6 : KIND_UNUSED7;
    end
    if (k == KIND_REMOVE) it = pick_live();
    if (k == KIND_GET && live_cnt != 0 && $urandom_range(0, 9) < 7) begin
      ps = 6'($urandom_range(0, int'(live_cnt) - 1));
    end
    issue(k, it, pr, ps, 1'b0, '0);
  endtask

  always @(posedge clk) begin : scoreboard
    list_reply_t want;
    list_reply_t got;
    list_reply_t guess;
    if (!rst_n) begin
      for (int i = 0; i < NUM_HANDLES; i++) link_mem[i] = '0;
      head_h = '0;
      tail_h = '0;
      live_cnt = '0;
      peak_cnt = '0;
      max_entries_m = 7'd64;
      reply_q.delete();
    end else begin
      if (cfg_wr_en) max_entries_m = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        guess = apply_request(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[17:12]);
        reply_q.push_back(req_typed ? req_typed_reply : guess);
      end
      if (out_tvalid && out_tready) begin
        got.ok = out_tuser;
        got.handle = out_tdata[5:0];
        got.count = out_tdata[12:6];
        got.peak = out_tdata[19:13];
        if (reply_q.size() == 0) begin
          note_error($sformatf("unexpected result transaction at cycle %0d", cycles));
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            note_error($sformatf(
              "cycle %0d: ok %0d/%0d handle %0d/%0d count %0d/%0d peak %0d/%0d (exp/act)",
              cycles, want.ok, got.ok, want.handle, got.handle, want.count, got.count,
              want.peak, got.peak));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(1, 40);
      end
      mode_left--;
      case (rx_mode)
        RX_STREAM: out_tready <= 1'b1;
        RX_CHOPPY: out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[bounded_linked_list_queue_core] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [5:0] order [NUM_HANDLES];
    logic [5:0] t;
    int j;
    int target;
    int caps [6];
    int counts [6];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_typed = 1'b0;
    req_typed_reply = '0;
    burst_left = 0;
    hold_requests = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_row(KIND_TAKE,      6'd0,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_REMOVE,    6'd5,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_GET,       6'd0,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_INS_AFTER, 6'd1,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_UNUSED6,   6'd0,  6'd0,  6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_UNUSED7,   6'd63, 6'd63, 6'd63, 1'b1, '{1'b0, 6'd0, 7'd0, 7'd0});
    add_row(KIND_APPEND,    6'd63, 6'd0,  6'd0,  1'b1, '{1'b1, 6'd0, 7'd1, 7'd1});
    add_row(KIND_FRONT,     6'd0,  6'd0,  6'd0,  1'b1, '{1'b1, 6'd0, 7'd2, 7'd2});
    add_row(KIND_APPEND,    6'd21, 6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_INS_AFTER, 6'd42, 6'd63, 6'd0,  1'b0, '0);
    add_row(KIND_INS_AFTER, 6'd7,  6'd21, 6'd0,  1'b0, '0);
    add_row(KIND_INS_AFTER, 6'd9,  6'd33, 6'd0,  1'b0, '0);
    add_row(KIND_GET,       6'd0,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_GET,       6'd0,  6'd0,  6'd4,  1'b0, '0);
    add_row(KIND_GET,       6'd0,  6'd0,  6'd5,  1'b0, '0);
    add_row(KIND_GET,       6'd0,  6'd0,  6'd63, 1'b0, '0);
    add_row(KIND_REMOVE,    6'd42, 6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_REMOVE,    6'd7,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_REMOVE,    6'd0,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_REMOVE,    6'd50, 6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_APPEND,    6'd63, 6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_TAKE,      6'd0,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_TAKE,      6'd0,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_TAKE,      6'd0,  6'd0,  6'd0,  1'b0, '0);
    add_row(KIND_TAKE,      6'd0,  6'd0,  6'd0,  1'b0, '0);
    for (int i = 0; i < directed_q.size(); i++) begin
      issue(directed_q[i].kind, directed_q[i].item, directed_q[i].prior, directed_q[i].pos,
            directed_q[i].typed, directed_q[i].reply);
    end

    // fill with every handle once so each link is written before random traffic
    set_max_entries(7'd64);
    for (int i = 0; i < NUM_HANDLES; i++) order[i] = 6'(i);
    for (int i = NUM_HANDLES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NUM_HANDLES; i++) issue(KIND_APPEND, order[i], 6'd0, 6'd0, 1'b0, '0);
    issue(KIND_APPEND, 6'd17, 6'd0, 6'd0, 1'b0, '0);
    issue(KIND_FRONT, 6'd40, 6'd0, 6'd0, 1'b0, '0);
    issue(KIND_INS_AFTER, 6'd3, order[10], 6'd0, 1'b0, '0);
    issue(KIND_GET, 6'd0, 6'd0, 6'd63, 1'b0, '0);
    issue(KIND_GET, 6'd0, 6'd0, 6'd0, 1'b0, '0);

    caps = '{64, 0, 1, 5, 0, 64};
    counts = '{70, 30, 45, 70, 70, 70};
    caps[4] = $urandom_range(2, 63);
    for (int p = 0; p < 6; p++) begin
      set_max_entries(7'(caps[p]));
      if (p == 2 || p == 4) hold_requests++;
      target = caps[p];
      for (int n = 0; n < counts[p]; n++) begin
        if (n % 30 == 0 && n != 0) target = $urandom_range(0, caps[p]);
        random_request(target);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && reply_q.size() == 0) begin
      $display("[bounded_linked_list_queue_core] OK");
    end else begin
      $display("[bounded_linked_list_queue_core] ERROR");
    end
    $finish;
  end

endmodule
